// ===== design/sbm_pkg.sv =====
package sbm_pkg;

    localparam int ENTRY_W     = 16;
    localparam int INDEX_W     = 13;
    localparam int LBA_W       = 32;
    localparam int PHYS_W      = 39;
    localparam int DISC_W      = 36;
    localparam int USED_W      = 14;
    localparam int SHIFT_W     = 5;
    localparam int OFFSET_W    = 22;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SHIFT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LBA    = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd22;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [LBA_W-1:0]   lba;
    } in_item_t;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_lba;
        logic              is_empty;
        logic              out_of_range;
        logic [DISC_W-1:0] disc_lbas;
    } out_item_t;

    // Control handed from the issue stage to the result stage.
    typedef struct packed {
        logic                valid;
        logic                translate;
        logic                out_of_range;
        logic [OFFSET_W-1:0] offset;
    } stage_t;

endpackage

// ===== design/sbm_map_ram.sv =====
module sbm_map_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [sbm_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [sbm_pkg::ENTRY_W-1:0] rd_data
);

    logic [sbm_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sbm_issue.sv =====
module sbm_issue #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  sbm_pkg::in_item_t           item,
    input  logic [sbm_pkg::SHIFT_W-1:0] shift,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [sbm_pkg::ENTRY_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    output sbm_pkg::stage_t             stage,
    output logic [sbm_pkg::USED_W-1:0]  used_blocks
);

    logic [sbm_pkg::USED_W-1:0]   used_blocks_reg;
    logic [sbm_pkg::USED_W-1:0]   used_blocks_next;
    sbm_pkg::stage_t              stage_reg;
    sbm_pkg::stage_t              stage_next;
    logic [31:0]                  idx_ext;
    logic [31:0]                  blk_ext;
    logic [sbm_pkg::USED_W-1:0]   idx_inc;
    logic [sbm_pkg::DISC_W-1:0]   disc_size;
    logic [sbm_pkg::LBA_W-1:0]    offset_mask;
    logic                         in_map;
    logic                         is_load;
    logic                         is_translate;
    logic                         beyond;

    assign idx_ext      = 32'(item.entry_index);
    assign blk_ext      = item.lba >> shift;
    assign idx_inc      = sbm_pkg::USED_W'(item.entry_index) + sbm_pkg::USED_W'(1);
    assign in_map       = idx_ext < 32'(DEPTH);
    assign is_load      = accept && (item.operation == sbm_pkg::OP_LOAD);
    assign is_translate = accept && (item.operation == sbm_pkg::OP_TRANSLATE);
    assign disc_size    = sbm_pkg::DISC_W'(used_blocks_reg) << shift;
    assign beyond       = sbm_pkg::DISC_W'(item.lba) >= disc_size;
    assign offset_mask  = (sbm_pkg::LBA_W'(1) << shift) - sbm_pkg::LBA_W'(1);

    assign wr_en   = is_load && in_map;
    assign wr_addr = idx_ext[ADDR_W-1:0];
    assign wr_data = item.entry_value;

    // An in-range block index is always below used_blocks, hence inside the map.
    assign rd_en   = is_translate && !beyond;
    assign rd_addr = blk_ext[ADDR_W-1:0];

    always_comb
    begin
        used_blocks_next = used_blocks_reg;
        if (wr_en && (item.entry_value != '0) && (idx_inc > used_blocks_reg))
        begin
            used_blocks_next = idx_inc;
        end
        stage_next.valid        = accept;
        stage_next.translate    = is_translate;
        stage_next.out_of_range = is_translate && beyond;
        stage_next.offset       = item.lba[sbm_pkg::OFFSET_W-1:0]
                                & offset_mask[sbm_pkg::OFFSET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_blocks_reg <= '0;
            stage_reg       <= '0;
        end
        else
        begin
            used_blocks_reg <= used_blocks_next;
            stage_reg       <= stage_next;
        end
    end

    assign stage       = stage_reg;
    assign used_blocks = used_blocks_reg;

endmodule

// ===== design/sbm_result.sv =====
module sbm_result (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbm_pkg::stage_t                stage,
    input  logic [sbm_pkg::ENTRY_W-1:0]    rd_data,
    input  logic [sbm_pkg::SHIFT_W-1:0]    shift,
    input  logic [sbm_pkg::CFG_DATA_W-1:0] base_lba,
    input  logic [sbm_pkg::USED_W-1:0]     used_blocks,
    output logic                           done,
    output sbm_pkg::out_item_t             result
);

    logic               done_reg;
    sbm_pkg::out_item_t result_reg;
    sbm_pkg::out_item_t result_next;
    logic               entry_zero;

    assign entry_zero = rd_data == '0;

    // Map data only counts for translations that passed the range check.
    always_comb
    begin
        result_next.phys_lba     = '0;
        result_next.is_empty     = 1'b0;
        result_next.out_of_range = stage.out_of_range;
        result_next.disc_lbas    = sbm_pkg::DISC_W'(used_blocks) << shift;
        if (stage.translate && !stage.out_of_range)
        begin
            if (entry_zero)
            begin
                result_next.is_empty = 1'b1;
            end
            else
            begin
                result_next.phys_lba = (sbm_pkg::PHYS_W'(rd_data) << shift)
                                     + sbm_pkg::PHYS_W'(stage.offset)
                                     + sbm_pkg::PHYS_W'(base_lba);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/sparse_block_map_translator.sv =====
// Sparse block map translator.
//
// An item is taken at a rising edge where start is high and busy is low. A load
// item writes one 16-bit block map entry and raises the used block count when
// the entry is nonzero; a translate item maps a virtual sector through the map
// to a physical sector, or flags it as empty or out of range. Each item gives
// exactly one result, shown on result for one cycle with done high. The map is
// read at the same edge that takes the item, and the shift and additions are
// registered at the next edge, where done rises with the result. The map has a
// single write port and a single read port, so one item enters every cycle and
// busy stays low.
// A load followed at once by a translate of the same block reads the new
// entry, since the write lands at the edge before the read.
// Configuration writes (block_shift, base_lba) are taken at any edge where
// cfg_we is high and must be issued only while no item is in flight.
// Reset clears the used block count and the stage and done registers, and sets
// the configuration registers to their reset values; the result register is
// not reset. Map contents are undefined until loaded, so no clearing pass runs.
// The receiver cannot hold results off and must take each one as it appears.
module sparse_block_map_translator #(
    parameter int MAP_ENTRIES = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sbm_pkg::in_item_t                 item,
    output logic                              done,
    output sbm_pkg::out_item_t                result,
    input  logic                              cfg_we,
    input  logic [sbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    logic [sbm_pkg::SHIFT_W-1:0]    block_shift_reg;
    logic [sbm_pkg::CFG_DATA_W-1:0] base_lba_reg;
    logic [sbm_pkg::SHIFT_W-1:0]    eff_shift;
    logic                           accept;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [sbm_pkg::ENTRY_W-1:0]    wr_data;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [sbm_pkg::ENTRY_W-1:0]    rd_data;
    sbm_pkg::stage_t                stage;
    logic [sbm_pkg::USED_W-1:0]     used_blocks;

    // The pipeline never stalls, so the block is always ready for an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Shifts above the largest supported block size saturate.
    assign eff_shift = (block_shift_reg > sbm_pkg::SHIFT_MAX) ? sbm_pkg::SHIFT_MAX
                                                              : block_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg <= sbm_pkg::SHIFT_RESET;
            base_lba_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbm_pkg::REG_BLOCK_SHIFT: block_shift_reg <= cfg_data[sbm_pkg::SHIFT_W-1:0];
                sbm_pkg::REG_BASE_LBA:    base_lba_reg    <= cfg_data;
                default:                  base_lba_reg    <= base_lba_reg;
            endcase
        end
    end

    sbm_issue #(
        .DEPTH  (MAP_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .shift       (eff_shift),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .stage       (stage),
        .used_blocks (used_blocks)
    );

    sbm_map_ram #(
        .DEPTH  (MAP_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbm_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .rd_data     (rd_data),
        .shift       (eff_shift),
        .base_lba    (base_lba_reg),
        .used_blocks (used_blocks),
        .done        (done),
        .result      (result)
    );

endmodule
